[rtl/cicp_pkg.sv]
`default_nettype none

package cicp_pkg;

	// request codes
	typedef enum logic [2:0] {
		CMD_PORT_READ  = 3'd0,
		CMD_PORT_WRITE = 3'd1,
		CMD_SET_WORD   = 3'd2,
		CMD_EVALUATE   = 3'd3,
		CMD_GET_VECTOR = 3'd4,
		CMD_ACKNOWLEDGE = 3'd5
	} cmd_code_t;

	// word select codes for set word
	localparam logic [1:0] WSEL_REQUEST = 2'd0;
	localparam logic [1:0] WSEL_MASK    = 2'd1;
	localparam logic [1:0] WSEL_SERVICE = 2'd2;

	// initialisation sequence position
	typedef enum logic [1:0] {
		STEP_ICW2 = 2'd0,
		STEP_ICW3 = 2'd1,
		STEP_ICW4 = 2'd2,
		STEP_OCW1 = 2'd3
	} init_step_t;

	// ocw2 operation field, bits 7:5
	localparam logic [2:0] OCW2_NS_EOI   = 3'b001;
	localparam logic [2:0] OCW2_SPEC_EOI = 3'b011;

	// ocw3 read select, bits 1:0
	localparam logic [1:0] RSEL_IRR = 2'b10;
	localparam logic [1:0] RSEL_ISR = 2'b11;

	localparam logic [3:0] CASCADE_LINE = 4'd2;
	localparam logic [7:0] POLL_FLAG    = 8'h80;
	localparam logic [7:0] BASE_MASK    = 8'hf8;

	// reset values, index 0 master, index 1 slave
	localparam logic [7:0] RST_ICW1       = 8'h11;
	localparam logic [7:0] RST_BASE_MST   = 8'h08;
	localparam logic [7:0] RST_BASE_SLV   = 8'h70;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	// index of the lowest set bit, 8 when none
	function automatic logic [3:0] low_index(input logic [7:0] v);
		logic [3:0] r;
		r = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

	// clear one bit, index 8 leaves the byte alone
	function automatic logic [7:0] clear_bit(input logic [7:0] v, input logic [3:0] idx);
		logic [7:0] r;
		r = v;
		if (!idx[3]) begin
			r[idx[2:0]] = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/cicp_ctrl.sv]
`default_nettype none

module cicp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cicp_pkg::ctrl_cmd_t    ctl
);
	import cicp_pkg::*;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		in_ready    = 1'b0;
		ctl         = '0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// result register free or drained at this edge
				if (!out_valid_q || out_ready) begin
					ctl.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/cicp_dp.sv]
`default_nettype none

module cicp_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cicp_pkg::ctrl_cmd_t ctl,
	input  wire logic [2:0]        cmd,
	input  wire logic              chip_sel,
	input  wire logic              port_a0,
	input  wire logic [7:0]        bus_byte,
	input  wire logic [1:0]        word_select,
	input  wire logic [15:0]       word_value,
	output logic [7:0]             read_data,
	output logic                   intr_pending,
	output logic [7:0]             vector,
	output logic [15:0]            mask_word,
	output logic [15:0]            service_word,
	output logic [15:0]            request_word
);
	import cicp_pkg::*;

	// latched request
	logic [2:0]  cmd_q;
	logic        chip_q;
	logic        a0_q;
	logic [7:0]  bus_q;
	logic [1:0]  wsel_q;
	logic [15:0] wval_q;

	// chip state, index 0 master, index 1 slave
	logic [7:0]  icw1_q [2];
	logic [7:0]  base_q [2];
	logic [7:0]  ocw3_q [2];
	logic [7:0]  mask_q [2];
	logic [7:0]  isr_q  [2];
	logic [7:0]  irr_q  [2];
	logic        slave_q [2];
	init_step_t  step_q [2];

	logic [7:0]  icw1_d [2];
	logic [7:0]  base_d [2];
	logic [7:0]  ocw3_d [2];
	logic [7:0]  mask_d [2];
	logic [7:0]  isr_d  [2];
	logic [7:0]  irr_d  [2];
	logic        slave_d [2];
	init_step_t  step_d [2];

	logic [7:0]  rd_q, rd_d;
	logic        pend_q, pend_d;
	logic [7:0]  vec_q, vec_d;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			chip_q <= chip_sel;
			a0_q   <= port_a0;
			bus_q  <= bus_byte;
			wsel_q <= word_select;
			wval_q <= word_value;
		end
		if (ctl.exec) begin
			rd_q   <= rd_d;
			pend_q <= pend_d;
			vec_q  <= vec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icw1_q[0]  <= RST_ICW1;
			icw1_q[1]  <= RST_ICW1;
			base_q[0]  <= RST_BASE_MST;
			base_q[1]  <= RST_BASE_SLV;
			ocw3_q[0]  <= '0;
			ocw3_q[1]  <= '0;
			mask_q[0]  <= '0;
			mask_q[1]  <= '0;
			isr_q[0]   <= '0;
			isr_q[1]   <= '0;
			irr_q[0]   <= '0;
			irr_q[1]   <= '0;
			slave_q[0] <= 1'b0;
			slave_q[1] <= 1'b1;
			step_q[0]  <= STEP_OCW1;
			step_q[1]  <= STEP_OCW1;
		end else if (ctl.exec) begin
			icw1_q  <= icw1_d;
			base_q  <= base_d;
			ocw3_q  <= ocw3_d;
			mask_q  <= mask_d;
			isr_q   <= isr_d;
			irr_q   <= irr_d;
			slave_q <= slave_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		logic [3:0] i;
		logic [3:0] j;
		logic [7:0] s1;
		logic [7:0] r0;
		logic       hold;

		icw1_d  = icw1_q;
		base_d  = base_q;
		ocw3_d  = ocw3_q;
		mask_d  = mask_q;
		isr_d   = isr_q;
		irr_d   = irr_q;
		slave_d = slave_q;
		step_d  = step_q;
		rd_d    = '0;
		pend_d  = 1'b0;
		vec_d   = '0;
		i       = low_index(isr_q[0]);
		j       = low_index(isr_q[1]);
		s1      = '0;
		r0      = '0;
		hold    = 1'b0;

		case (cmd_q)
			CMD_PORT_READ: begin
				if (a0_q) begin
					rd_d = mask_q[chip_q];
				end else if (ocw3_q[chip_q][2]) begin
					// poll byte
					if (irr_q[chip_q] != '0) begin
						rd_d = POLL_FLAG | {4'd0, low_index(isr_q[chip_q])};
					end
				end else begin
					case (ocw3_q[chip_q][1:0])
						RSEL_IRR: rd_d = irr_q[chip_q];
						RSEL_ISR: rd_d = isr_q[chip_q];
						default:  rd_d = bus_q;
					endcase
				end
			end
			CMD_PORT_WRITE: begin
				if (a0_q) begin
					case (step_q[chip_q])
						STEP_ICW2: begin
							base_d[chip_q] = bus_q & BASE_MASK;
							if (!icw1_q[chip_q][1]) begin
								step_d[chip_q] = STEP_ICW3;
							end else if (icw1_q[chip_q][0]) begin
								step_d[chip_q] = STEP_ICW4;
							end else begin
								step_d[chip_q] = STEP_OCW1;
							end
						end
						STEP_ICW3: begin
							step_d[chip_q] = icw1_q[chip_q][0] ? STEP_ICW4 : STEP_OCW1;
						end
						STEP_ICW4: begin
							slave_d[chip_q] = !bus_q[2];
							step_d[chip_q]  = STEP_OCW1;
						end
						default: begin
							mask_d[chip_q] = bus_q;
						end
					endcase
				end else if (bus_q[4]) begin
					icw1_d[chip_q] = bus_q;
					step_d[chip_q] = STEP_ICW2;
				end else if (bus_q[3]) begin
					ocw3_d[chip_q] = bus_q;
				end else if (bus_q[7:5] == OCW2_NS_EOI) begin
					i    = low_index(isr_q[chip_q]);
					// master keeps line 2 while the slave still serves an unmasked line
					hold = !slave_q[chip_q] && (i == CASCADE_LINE) &&
						((isr_q[1] & ~mask_q[1]) != '0);
					if (!hold) begin
						isr_d[chip_q] = clear_bit(isr_q[chip_q], i);
					end
				end else if (bus_q[7:5] == OCW2_SPEC_EOI) begin
					isr_d[chip_q] = clear_bit(isr_q[chip_q], {1'b0, bus_q[2:0]});
				end
			end
			CMD_SET_WORD: begin
				case (wsel_q)
					WSEL_REQUEST: begin
						irr_d[0] = wval_q[7:0];
						irr_d[1] = wval_q[15:8];
					end
					WSEL_MASK: begin
						mask_d[0] = wval_q[7:0];
						mask_d[1] = wval_q[15:8];
					end
					WSEL_SERVICE: begin
						isr_d[0] = wval_q[7:0];
						isr_d[1] = wval_q[15:8];
					end
					default: begin
					end
				endcase
			end
			CMD_EVALUATE: begin
				s1       = irr_q[1] & ~mask_q[1];
				r0       = irr_q[0];
				if (s1 != '0) begin
					r0[CASCADE_LINE[2:0]] = 1'b1;
				end
				isr_d[1] = s1;
				irr_d[0] = r0;
				isr_d[0] = r0 & ~mask_q[0];
				pend_d   = ((r0 & ~mask_q[0]) != '0);
			end
			CMD_GET_VECTOR: begin
				if (i == CASCADE_LINE) begin
					vec_d = {4'd0, j} | base_q[1];
				end else begin
					vec_d = {4'd0, i} | base_q[0];
				end
			end
			CMD_ACKNOWLEDGE: begin
				if (i == CASCADE_LINE) begin
					s1       = clear_bit(isr_q[1], j);
					isr_d[1] = s1;
					irr_d[1] = clear_bit(irr_q[1], j);
					if (s1 == '0) begin
						isr_d[0] = clear_bit(isr_q[0], CASCADE_LINE);
						irr_d[0] = clear_bit(irr_q[0], CASCADE_LINE);
					end
				end else begin
					isr_d[0] = clear_bit(isr_q[0], i);
					irr_d[0] = clear_bit(irr_q[0], i);
				end
			end
			default: begin
			end
		endcase
	end

	assign read_data    = rd_q;
	assign intr_pending = pend_q;
	assign vector       = vec_q;
	assign mask_word    = {mask_q[1], mask_q[0]};
	assign service_word = {isr_q[1], isr_q[0]};
	assign request_word = {irr_q[1], irr_q[0]};

endmodule

`default_nettype wire

[rtl/cascaded_interrupt_controller_pair.sv]
`default_nettype none

// channel   direction  handshake              payload
// request   in         in_valid / in_ready    cmd chip_sel port_a0 bus_byte word_select word_value
// result    out        out_valid / out_ready  read_data intr_pending vector mask_word
//                                             service_word request_word
//
// a request is handled as a latch step, then an execute step in which the
// datapath updates both chips and loads the result register
// a new request is taken while the previous result still waits at the output
// the execute cycle holds while the result register is full and not being taken
// reset loads the built-in initialisation: master base 0x08, slave base 0x70,
// both chips past initialisation, all masks, requests and services clear
module cascaded_interrupt_controller_pair (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  cmd,
	input  wire logic        chip_sel,
	input  wire logic        port_a0,
	input  wire logic [7:0]  bus_byte,
	input  wire logic [1:0]  word_select,
	input  wire logic [15:0] word_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	output logic             intr_pending,
	output logic [7:0]       vector,
	output logic [15:0]      mask_word,
	output logic [15:0]      service_word,
	output logic [15:0]      request_word
);
	import cicp_pkg::*;

	// command strobes from the sequencer into the datapath
	ctrl_cmd_t ctl;

	// sequencer: idle / execute, owns the result valid flag
	cicp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// datapath: request latch, both chips' registers, priority logic, result register
	cicp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.chip_sel     (chip_sel),
		.port_a0      (port_a0),
		.bus_byte     (bus_byte),
		.word_select  (word_select),
		.word_value   (word_value),
		.read_data    (read_data),
		.intr_pending (intr_pending),
		.vector       (vector),
		.mask_word    (mask_word),
		.service_word (service_word),
		.request_word (request_word)
	);

	// only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// an execute step always presents a result
	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> out_valid)
		else $error("execute step without result");

	// a pending interrupt means the master has a line in service
	a_pending_service: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && intr_pending) |-> (service_word[7:0] != 8'h00))
		else $error("pending reported with empty master service register");

	// the sequencer never loads and executes together
	a_load_exec_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.exec))
		else $error("load and execute in the same cycle");

endmodule

`default_nettype wire

[tb/sv/tb_cascaded_interrupt_controller_pair.sv]
`default_nettype none

module tb_cascaded_interrupt_controller_pair;
	import cicp_pkg::*;

	// codes the package leaves unnamed: spare commands and the spare word select
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [1:0] WSEL_SPARE   = 2'd3;

	// command byte marks and fields
	localparam logic [7:0] ICW1_TAG      = 8'h10;
	localparam logic [7:0] ICW1_SNGL     = 8'h02;
	localparam logic [7:0] ICW1_IC4      = 8'h01;
	localparam logic [7:0] ICW4_MASTER   = 8'h04;
	localparam logic [7:0] OCW3_TAG      = 8'h08;
	localparam logic [7:0] OCW3_POLL     = 8'h04;
	localparam logic [2:0] OCW2_SET_PRIO = 3'b110;

	// slave output lands on master line 2
	localparam logic [3:0] SLAVE_LINE = 4'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        chip;
		logic        a0;
		logic [7:0]  bus;
		logic [1:0]  wsel;
		logic [15:0] wval;
	} pic_req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        intr;
		logic [7:0]  vector;
		logic [15:0] masks;
		logic [15:0] services;
		logic [15:0] requests;
	} pic_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic        chip_sel;
	logic        port_a0;
	logic [7:0]  bus_byte;
	logic [1:0]  word_select;
	logic [15:0] word_value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_data;
	logic        intr_pending;
	logic [7:0]  vector;
	logic [15:0] mask_word;
	logic [15:0] service_word;
	logic [15:0] request_word;

	// request on the bus, held until taken
	pic_req_t req_drv;
	logic     req_fire;

	pic_req_t pending_requests [$];
	pic_res_t predicted_replies [$];

	int mismatches;
	int send_gap_pct;
	int recv_stall_pct;

	// predicted chip state, index 0 master, index 1 slave
	logic [7:0] chip_icw1 [2];
	logic [7:0] chip_base [2];
	logic [7:0] chip_ocw3 [2];
	logic [7:0] chip_imr [2];
	logic [7:0] chip_isr [2];
	logic [7:0] chip_irr [2];
	logic       chip_is_slave [2];
	init_step_t chip_init_step [2];

	assign cmd         = req_drv.cmd;
	assign chip_sel    = req_drv.chip;
	assign port_a0     = req_drv.a0;
	assign bus_byte    = req_drv.bus;
	assign word_select = req_drv.wsel;
	assign word_value  = req_drv.wval;

	cascaded_interrupt_controller_pair dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.chip_sel     (chip_sel),
		.port_a0      (port_a0),
		.bus_byte     (bus_byte),
		.word_select  (word_select),
		.word_value   (word_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.intr_pending (intr_pending),
		.vector       (vector),
		.mask_word    (mask_word),
		.service_word (service_word),
		.request_word (request_word)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// lowest active line, 8 when the byte is empty
	function automatic logic [3:0] lowest_line(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd8;
		for (int k = 0; k < 8; k++) begin
			if (v[k] && n == 4'd8) begin
				n = 4'(k);
			end
		end
		return n;
	endfunction

	// line 8 means no line, byte untouched
	function automatic logic [7:0] drop_line(input logic [7:0] v, input logic [3:0] idx);
		logic [7:0] r;
		r = v;
		if (idx < 4'd8) begin
			r[idx[2:0]] = 1'b0;
		end
		return r;
	endfunction

	// advance the predicted pair by one request and return what the block should report
	function automatic pic_res_t pic_pair_step(input pic_req_t r);
		pic_res_t res;
		logic c;
		logic [3:0] idx;
		logic hold;
		res = '0;
		c = r.chip;
		case (r.cmd)
		CMD_PORT_READ: begin
			if (r.a0) begin
				res.read_data = chip_imr[c];
			end else if ((chip_ocw3[c] & OCW3_POLL) != 8'h00) begin
				// poll byte: flag plus lowest in-service line, only with a live request
				res.read_data = (chip_irr[c] != 8'h00) ? {4'h8, lowest_line(chip_isr[c])} : 8'h00;
			end else begin
				case (chip_ocw3[c][1:0])
				RSEL_IRR: res.read_data = chip_irr[c];
				RSEL_ISR: res.read_data = chip_isr[c];
				default:  res.read_data = r.bus;
				endcase
			end
		end
		CMD_PORT_WRITE: begin
			if (!r.a0) begin
				if ((r.bus & ICW1_TAG) != 8'h00) begin
					chip_icw1[c] = r.bus;
					chip_init_step[c] = STEP_ICW2;
				end else if ((r.bus & OCW3_TAG) != 8'h00) begin
					chip_ocw3[c] = r.bus;
				end else if (r.bus[7:5] == OCW2_NS_EOI) begin
					// master keeps the cascade line while the slave still serves unmasked
					idx = lowest_line(chip_isr[c]);
					hold = !chip_is_slave[c] && idx == SLAVE_LINE &&
						(chip_isr[1] & ~chip_imr[1]) != 8'h00;
					if (!hold) begin
						chip_isr[c] = drop_line(chip_isr[c], idx);
					end
				end else if (r.bus[7:5] == OCW2_SPEC_EOI) begin
					chip_isr[c] = drop_line(chip_isr[c], {1'b0, r.bus[2:0]});
				end
			end else begin
				case (chip_init_step[c])
				STEP_ICW2: begin
					chip_base[c] = {r.bus[7:3], 3'b000};
					if ((chip_icw1[c] & ICW1_SNGL) == 8'h00) begin
						chip_init_step[c] = STEP_ICW3;
					end else if ((chip_icw1[c] & ICW1_IC4) != 8'h00) begin
						chip_init_step[c] = STEP_ICW4;
					end else begin
						chip_init_step[c] = STEP_OCW1;
					end
				end
				STEP_ICW3: begin
					chip_init_step[c] = ((chip_icw1[c] & ICW1_IC4) != 8'h00) ? STEP_ICW4 : STEP_OCW1;
				end
				STEP_ICW4: begin
					chip_is_slave[c] = (r.bus & ICW4_MASTER) == 8'h00;
					chip_init_step[c] = STEP_OCW1;
				end
				default: chip_imr[c] = r.bus;
				endcase
			end
		end
		CMD_SET_WORD: begin
			case (r.wsel)
			WSEL_REQUEST: {chip_irr[1], chip_irr[0]} = r.wval;
			WSEL_MASK:    {chip_imr[1], chip_imr[0]} = r.wval;
			WSEL_SERVICE: {chip_isr[1], chip_isr[0]} = r.wval;
			default: ;
			endcase
		end
		CMD_EVALUATE: begin
			chip_isr[1] = chip_irr[1] & ~chip_imr[1];
			if (chip_isr[1] != 8'h00) begin
				chip_irr[0][SLAVE_LINE[2:0]] = 1'b1;
			end
			chip_isr[0] = chip_irr[0] & ~chip_imr[0];
			res.intr = chip_isr[0] != 8'h00;
		end
		CMD_GET_VECTOR: begin
			idx = lowest_line(chip_isr[0]);
			if (idx == SLAVE_LINE) begin
				res.vector = {4'h0, lowest_line(chip_isr[1])} | chip_base[1];
			end else begin
				res.vector = {4'h0, idx} | chip_base[0];
			end
		end
		CMD_ACKNOWLEDGE: begin
			idx = lowest_line(chip_isr[0]);
			if (idx == SLAVE_LINE) begin
				idx = lowest_line(chip_isr[1]);
				chip_isr[1] = drop_line(chip_isr[1], idx);
				chip_irr[1] = drop_line(chip_irr[1], idx);
				// cascade line released only once the slave is empty
				if (chip_isr[1] == 8'h00) begin
					chip_isr[0] = drop_line(chip_isr[0], SLAVE_LINE);
					chip_irr[0] = drop_line(chip_irr[0], SLAVE_LINE);
				end
			end else begin
				chip_isr[0] = drop_line(chip_isr[0], idx);
				chip_irr[0] = drop_line(chip_irr[0], idx);
			end
		end
		default: ;
		endcase
		res.masks    = {chip_imr[1], chip_imr[0]};
		res.services = {chip_isr[1], chip_isr[0]};
		res.requests = {chip_irr[1], chip_irr[0]};
		return res;
	endfunction

	// every field random, callers override the ones that matter
	function automatic pic_req_t random_req();
		pic_req_t r;
		r.cmd  = 3'($urandom_range(7));
		r.chip = 1'($urandom_range(1));
		r.a0   = 1'($urandom_range(1));
		r.bus  = 8'($urandom);
		r.wsel = 2'($urandom_range(3));
		r.wval = 16'($urandom);
		return r;
	endfunction

	task automatic port_req(input logic [2:0] op, input logic chip, input logic a0,
			input logic [7:0] b);
		pic_req_t r;
		r = random_req();
		r.cmd = op;
		r.chip = chip;
		r.a0 = a0;
		r.bus = b;
		pending_requests.push_back(r);
	endtask

	task automatic word_req(input logic [1:0] sel, input logic [15:0] w);
		pic_req_t r;
		r = random_req();
		r.cmd = CMD_SET_WORD;
		r.wsel = sel;
		r.wval = w;
		pending_requests.push_back(r);
	endtask

	task automatic bare_req(input logic [2:0] op);
		pic_req_t r;
		r = random_req();
		r.cmd = op;
		pending_requests.push_back(r);
	endtask

	// mostly well-formed sequences: interrupt cycles, status reads, re-inits,
	// with word overwrites and fully random requests as noise
	task automatic queue_random(input int count);
		int target;
		logic ch;
		logic [7:0] icw1;
		logic [7:0] icw4;
		target = pending_requests.size() + count;
		while (pending_requests.size() < target) begin
			ch = 1'($urandom_range(1));
			case ($urandom_range(9))
			0, 1, 2, 3: begin
				// raise some lines, maybe mask a few, evaluate, then service them
				word_req(WSEL_REQUEST, 16'($urandom & $urandom));
				if ($urandom_range(1) == 1) begin
					word_req(WSEL_MASK, 16'($urandom & $urandom & $urandom));
				end
				bare_req(CMD_EVALUATE);
				repeat ($urandom_range(4, 1)) begin
					case ($urandom_range(4))
					0: bare_req(CMD_GET_VECTOR);
					1, 2: bare_req(CMD_ACKNOWLEDGE);
					3: port_req(CMD_PORT_WRITE, ch, 1'b0, {OCW2_NS_EOI, 2'b00, 3'($urandom)});
					default: port_req(CMD_PORT_WRITE, ch, 1'b0,
						{OCW2_SPEC_EOI, 2'b00, 3'($urandom)});
					endcase
				end
			end
			4, 5: begin
				// ocw3 select or poll, then reads of either port
				port_req(CMD_PORT_WRITE, ch, 1'b0, (8'($urandom) & ~ICW1_TAG) | OCW3_TAG);
				repeat ($urandom_range(2, 1)) begin
					port_req(CMD_PORT_READ, ch, 1'($urandom_range(1)), 8'($urandom));
				end
			end
			6: begin
				// full initialisation, roles mostly kept
				icw1 = 8'($urandom) | ICW1_TAG;
				port_req(CMD_PORT_WRITE, ch, 1'b0, icw1);
				port_req(CMD_PORT_WRITE, ch, 1'b1, 8'($urandom));
				if ((icw1 & ICW1_SNGL) == 8'h00) begin
					port_req(CMD_PORT_WRITE, ch, 1'b1, 8'($urandom));
				end
				if ((icw1 & ICW1_IC4) != 8'h00) begin
					icw4 = 8'($urandom);
					if ($urandom_range(7) != 0) begin
						icw4 = ch ? (icw4 & ~ICW4_MASTER) : (icw4 | ICW4_MASTER);
					end
					port_req(CMD_PORT_WRITE, ch, 1'b1, icw4);
				end
				port_req(CMD_PORT_WRITE, ch, 1'b1, 8'($urandom & $urandom));
			end
			7: word_req(2'($urandom_range(3)), 16'($urandom));
			default: pending_requests.push_back(random_req());
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// driver: payload and valid change on the falling edge only
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			// a new request may go up once the bus is free or the last one was taken
			if (!in_valid || req_fire) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					req_drv <= pending_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		pic_res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_replies.push_back(pic_pair_step(req_drv));
			end
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0) begin
					$display("%0t result with no request outstanding: expected none, got %h %h %h",
						$time, mask_word, service_word, request_word);
					mismatches++;
				end else begin
					want = predicted_replies.pop_front();
					check_field("read_data", 16'(want.read_data), 16'(read_data));
					check_field("intr_pending", 16'(want.intr), 16'(intr_pending));
					check_field("vector", 16'(want.vector), 16'(vector));
					check_field("mask_word", want.masks, mask_word);
					check_field("service_word", want.services, service_word);
					check_field("request_word", want.requests, request_word);
				end
			end
		end
		req_fire <= in_valid && in_ready;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		req_fire = 1'b0;
		req_drv = '0;
		mismatches = 0;

		// built-in initialisation of both chips
		chip_icw1[0] = 8'h11;
		chip_icw1[1] = 8'h11;
		chip_base[0] = 8'h08;
		chip_base[1] = 8'h70;
		chip_ocw3[0] = 8'h00;
		chip_ocw3[1] = 8'h00;
		chip_imr[0] = 8'h00;
		chip_imr[1] = 8'h00;
		chip_isr[0] = 8'h00;
		chip_isr[1] = 8'h00;
		chip_irr[0] = 8'h00;
		chip_irr[1] = 8'h00;
		chip_is_slave[0] = 1'b0;
		chip_is_slave[1] = 1'b1;
		chip_init_step[0] = STEP_OCW1;
		chip_init_step[1] = STEP_OCW1;

		// first phase: sender gaps now and then, receiver stalls a lot
		send_gap_pct = 31;
		recv_stall_pct = 74;

		// mask read after reset, unselected command read hands back the bus byte
		port_req(CMD_PORT_READ, 1'b0, 1'b1, 8'hff);
		port_req(CMD_PORT_READ, 1'b1, 1'b0, 8'ha5);
		// nothing in service: vector is the base with index eight, acknowledge is a no-op
		bare_req(CMD_GET_VECTOR);
		bare_req(CMD_ACKNOWLEDGE);
		// slave lines 0 and 7 plus master line 2
		word_req(WSEL_REQUEST, 16'h8104);
		bare_req(CMD_EVALUATE);
		bare_req(CMD_GET_VECTOR);
		// non-specific eoi on master line 2 is held while the slave still serves
		port_req(CMD_PORT_WRITE, 1'b0, 1'b0, {OCW2_NS_EOI, 5'd0});
		bare_req(CMD_ACKNOWLEDGE);
		// poll the master, then read the slave in-service register
		port_req(CMD_PORT_WRITE, 1'b0, 1'b0, OCW3_TAG | OCW3_POLL);
		port_req(CMD_PORT_READ, 1'b0, 1'b0, 8'h00);
		port_req(CMD_PORT_WRITE, 1'b1, 1'b0, OCW3_TAG | {6'd0, RSEL_ISR});
		port_req(CMD_PORT_READ, 1'b1, 1'b0, 8'h5a);
		// specific eoi empties the slave, acknowledge then frees the cascade line
		port_req(CMD_PORT_WRITE, 1'b1, 1'b0, {OCW2_SPEC_EOI, 5'd7});
		bare_req(CMD_ACKNOWLEDGE);
		// ocw3 with the top bit set is only stored, read falls back to the bus
		port_req(CMD_PORT_WRITE, 1'b1, 1'b0, 8'h80 | OCW3_TAG);
		port_req(CMD_PORT_READ, 1'b1, 1'b0, 8'h3c);
		// cascade line in service with an empty slave: slave base with index eight
		word_req(WSEL_SERVICE, 16'h0004);
		bare_req(CMD_GET_VECTOR);
		// non-specific eoi on an empty slave, set-priority code on the master
		port_req(CMD_PORT_WRITE, 1'b1, 1'b0, {OCW2_NS_EOI, 5'd0});
		port_req(CMD_PORT_WRITE, 1'b0, 1'b0, {OCW2_SET_PRIO, 5'd0});
		// spare word select with all ones, spare commands
		word_req(WSEL_SPARE, 16'hffff);
		bare_req(CMD_SPARE_LO);
		bare_req(CMD_SPARE_HI);
		// slave re-init through icw3 and an icw4 that keeps it a slave
		port_req(CMD_PORT_WRITE, 1'b1, 1'b0, ICW1_TAG | ICW1_IC4);
		port_req(CMD_PORT_WRITE, 1'b1, 1'b1, 8'hff);
		port_req(CMD_PORT_WRITE, 1'b1, 1'b1, 8'h00);
		port_req(CMD_PORT_WRITE, 1'b1, 1'b1, 8'h01);
		// master single mode without ic4: straight to the mask after icw2
		port_req(CMD_PORT_WRITE, 1'b0, 1'b0, ICW1_TAG | ICW1_SNGL);
		port_req(CMD_PORT_WRITE, 1'b0, 1'b1, 8'h20);
		port_req(CMD_PORT_WRITE, 1'b0, 1'b1, 8'h00);

		queue_random(170);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0) @(posedge clk);
		// second phase: roles of the two sides swapped
		send_gap_pct = 74;
		recv_stall_pct = 31;
		queue_random(170);

		while (pending_requests.size() != 0) @(posedge clk);
		// last phase: back to back on both sides
		send_gap_pct = 0;
		recv_stall_pct = 0;
		queue_random(170);

		while (pending_requests.size() != 0 || in_valid || predicted_replies.size() != 0) begin
			@(posedge clk);
		end
		// let the clock run on to catch any stray result
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 200000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
